// ----- src/wsd_pkg.sv -----
// shared types and constants of the websocket frame deframer
package wsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CLOSE_BYTE  = 8'd136;
  localparam logic [7:0] FIN_BIT     = 8'h80;
  localparam logic [7:0] OPCODE_MASK = 8'h0f;
  localparam logic [7:0] MASK_BIT    = 8'd128;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_EMPTY_DONE = 3'd1,
    KIND_CLOSE      = 3'd2,
    KIND_BAD_HEADER = 3'd3,
    KIND_UNMASKED   = 3'd4
  } wsd_kind_t;

  // one classified result on its way to the output stage
  typedef struct packed {
    wsd_kind_t  kind;
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic       last;
  } wsd_op_t;

endpackage

// ----- src/wsd_front.sv -----
// header parser: tracks frame phase, length and mask key, classifies each byte
module wsd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              push,
  output wsd_pkg::wsd_op_t  push_op
);

  typedef enum logic [2:0] {
    PH_HDR1  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_LEN16 = 3'd2,
    PH_LEN64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  first_hdr_r, first_hdr_nxt;
  logic [63:0] rem_len_r, rem_len_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        closed_r, closed_nxt;

  logic [63:0] rem_dec;
  logic [7:0]  key_sel;

  assign rem_dec = (rem_len_r != 64'd0) ? rem_len_r - 64'd1 : rem_len_r;

  always_comb begin
    case (pos_r)
      2'd0:    key_sel = key_r[31:24];
      2'd1:    key_sel = key_r[23:16];
      2'd2:    key_sel = key_r[15:8];
      default: key_sel = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    first_hdr_nxt = first_hdr_r;
    rem_len_nxt   = rem_len_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    closed_nxt    = closed_r;
    push          = 1'b0;
    push_op       = '{kind: wsd_pkg::KIND_PAYLOAD, raw_byte: 8'd0, key_byte: 8'd0, last: 1'b0};

    if (take && !closed_r) begin
      case (phase_r)
        PH_HDR2: begin
          if (first_hdr_r == wsd_pkg::CLOSE_BYTE) begin
            push         = 1'b1;
            push_op.kind = wsd_pkg::KIND_CLOSE;
            closed_nxt   = 1'b1;
            phase_nxt    = PH_HDR1;
          end else if ((first_hdr_r & wsd_pkg::FIN_BIT) == 8'd0 ||
                       (first_hdr_r & wsd_pkg::OPCODE_MASK) == 8'd0) begin
            push         = 1'b1;
            push_op.kind = wsd_pkg::KIND_BAD_HEADER;
            closed_nxt   = 1'b1;
            phase_nxt    = PH_HDR1;
          end else if (rx_byte < wsd_pkg::MASK_BIT) begin
            push         = 1'b1;
            push_op.kind = wsd_pkg::KIND_UNMASKED;
            closed_nxt   = 1'b1;
            phase_nxt    = PH_HDR1;
          end else begin
            cnt_nxt = 3'd0;
            key_nxt = 32'd0;
            pos_nxt = 2'd0;
            if (rx_byte[6:0] == wsd_pkg::LEN_EXT16) begin
              rem_len_nxt = 64'd0;
              phase_nxt   = PH_LEN16;
            end else if (rx_byte[6:0] == wsd_pkg::LEN_EXT64) begin
              rem_len_nxt = 64'd0;
              phase_nxt   = PH_LEN64;
            end else begin
              rem_len_nxt = {57'd0, rx_byte[6:0]};
              phase_nxt   = PH_MASK;
            end
          end
        end
        PH_LEN16, PH_LEN64: begin
          rem_len_nxt = {rem_len_r[55:0], rx_byte};
          cnt_nxt     = cnt_r + 3'd1;
          if ((phase_r == PH_LEN16 && cnt_r == 3'd1) ||
              (phase_r == PH_LEN64 && cnt_r == 3'd7)) begin
            cnt_nxt   = 3'd0;
            phase_nxt = PH_MASK;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            cnt_nxt = 3'd0;
            pos_nxt = 2'd0;
            if (rem_len_r == 64'd0) begin
              push         = 1'b1;
              push_op.kind = wsd_pkg::KIND_EMPTY_DONE;
              push_op.last = 1'b1;
              phase_nxt    = PH_HDR1;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          pos_nxt          = pos_r + 2'd1;
          rem_len_nxt      = rem_dec;
          push             = 1'b1;
          push_op.raw_byte = rx_byte;
          push_op.key_byte = key_sel;
          push_op.last     = (rem_dec == 64'd0);
          if (rem_dec == 64'd0) begin
            phase_nxt = PH_HDR1;
          end
        end
        default: begin
          first_hdr_nxt = rx_byte;
          phase_nxt     = PH_HDR2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR1;
      first_hdr_r <= 8'd0;
      rem_len_r   <= 64'd0;
      cnt_r       <= 3'd0;
      key_r       <= 32'd0;
      pos_r       <= 2'd0;
      closed_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      first_hdr_r <= first_hdr_nxt;
      rem_len_r   <= rem_len_nxt;
      cnt_r       <= cnt_nxt;
      key_r       <= key_nxt;
      pos_r       <= pos_nxt;
      closed_r    <= closed_nxt;
    end
  end

endmodule

// ----- src/wsd_queue.sv -----
// small fifo of classified results between parser and output stage
module wsd_queue #(
  parameter int unsigned DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wsd_pkg::wsd_op_t  push_op,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output wsd_pkg::wsd_op_t  head_op
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  wsd_pkg::wsd_op_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- src/wsd_back.sv -----
// output stage: unmasks payload bytes and holds the result beat
module wsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  wsd_pkg::wsd_op_t  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [7:0]        out_data_byte,
  output logic              out_last_of_frame
);

  logic       valid_r;
  logic [2:0] kind_r;
  logic [7:0] data_r;
  logic       last_r;

  assign q_pop = q_not_empty && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_head.kind;
      data_r <= (q_head.kind == wsd_pkg::KIND_PAYLOAD) ?
                (q_head.raw_byte ^ q_head.key_byte) : 8'd0;
      last_r <= q_head.last;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = kind_r;
  assign out_data_byte     = data_r;
  assign out_last_of_frame = last_r;

endmodule

// ----- src/websocket_frame_deframer_unit.sv -----
// top level of the websocket frame deframer: parser, result fifo, output stage
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, in_rx_byte[7:0]              | sink
//  out     | out_valid, out_ready, out_kind[2:0],             | source
//          | out_data_byte[7:0], out_last_of_frame            |
//
// one received byte per beat; the parser takes a byte every cycle that the fifo has room
// a beat with a result is written to the fifo after acceptance, then registered in the output stage
// header, length and mask bytes give no beat, except the empty-frame completion and a close or error result
// after close or error all bytes are dropped
// out stalls fill the fifo and only then drop in_ready; in keeps flowing meanwhile
// synchronous active-low reset returns to the first-header-byte phase with an empty fifo
module websocket_frame_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last_of_frame
);

  logic             q_full;
  logic             q_not_empty;
  logic             q_push;
  logic             q_pop;
  logic             take;
  wsd_pkg::wsd_op_t push_op;
  wsd_pkg::wsd_op_t head_op;

  // a byte is taken whenever there is room for a possible result
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // front: phase tracking and classification of each byte
  wsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .push    (q_push),
    .push_op (push_op)
  );

  // decoupling fifo, lets output stalls not block the parser at once
  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (push_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  // back: unmask and register the result beat
  wsd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (head_op),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// ----- tb/deframe_checker.sv -----
// checker for the websocket deframer: predicts results from input beats, compares output beats
module deframe_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_kind,
  input  logic [7:0] out_data_byte,
  input  logic       out_last_of_frame,
  output int         mismatch_count,
  output int         deframed_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_HEAD1   = 3'd0,
    ST_HEAD2   = 3'd1,
    ST_LEN16   = 3'd2,
    ST_LEN64   = 3'd3,
    ST_KEY     = 3'd4,
    ST_PAYLOAD = 3'd5
  } parse_state_t;

  typedef struct packed {
    wsd_pkg::wsd_kind_t kind;
    logic [7:0]         data;
    logic               last;
  } deframed_t;

  parse_state_t st;
  logic [7:0]   head_byte;
  logic [63:0]  bytes_left;
  logic [2:0]   field_cnt;
  logic [31:0]  key;
  logic [1:0]   key_pos;
  logic         closed;
  deframed_t    deframed_q[$];

  function void deframe_rx_byte(input logic [7:0] b, output bit produced,
                                output deframed_t res);
    logic [7:0] key_byte;
    produced = 1'b0;
    res.kind = wsd_pkg::KIND_PAYLOAD;
    res.data = 8'h00;
    res.last = 1'b0;
    if (closed) return;
    case (st)
      ST_HEAD2: begin
        // header checks, in priority order
        if (head_byte == wsd_pkg::CLOSE_BYTE) res.kind = wsd_pkg::KIND_CLOSE;
        else if ((head_byte & wsd_pkg::FIN_BIT) == 8'h00 ||
                 (head_byte & wsd_pkg::OPCODE_MASK) == 8'h00)
          res.kind = wsd_pkg::KIND_BAD_HEADER;
        else if (b < wsd_pkg::MASK_BIT) res.kind = wsd_pkg::KIND_UNMASKED;
        if (res.kind != wsd_pkg::KIND_PAYLOAD) begin
          closed   = 1'b1;
          st       = ST_HEAD1;
          produced = 1'b1;
        end else begin
          field_cnt = 3'd0;
          key       = 32'h0;
          key_pos   = 2'd0;
          if (b[6:0] == wsd_pkg::LEN_EXT16) begin
            bytes_left = 64'h0;
            st         = ST_LEN16;
          end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
            bytes_left = 64'h0;
            st         = ST_LEN64;
          end else begin
            bytes_left = 64'(b[6:0]);
            st         = ST_KEY;
          end
        end
      end
      ST_LEN16, ST_LEN64: begin
        bytes_left = {bytes_left[55:0], b};
        field_cnt  = field_cnt + 3'd1;
        if ((st == ST_LEN16 && field_cnt == 3'd2) || (st == ST_LEN64 && field_cnt == 3'd0)) begin
          field_cnt = 3'd0;
          st        = ST_KEY;
        end
      end
      ST_KEY: begin
        key       = {key[23:0], b};
        field_cnt = field_cnt + 3'd1;
        if (field_cnt == 3'd4) begin
          field_cnt = 3'd0;
          key_pos   = 2'd0;
          if (bytes_left == 64'h0) begin
            st       = ST_HEAD1;
            produced = 1'b1;
            res.kind = wsd_pkg::KIND_EMPTY_DONE;
            res.last = 1'b1;
          end else begin
            st = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        key_byte = 8'(key >> (8 * (3 - int'(key_pos))));
        key_pos  = key_pos + 2'd1;
        if (bytes_left != 64'h0) bytes_left = bytes_left - 64'd1;
        produced = 1'b1;
        res.data = b ^ key_byte;
        res.last = (bytes_left == 64'h0);
        if (bytes_left == 64'h0) st = ST_HEAD1;
      end
      default: begin
        head_byte = b;
        st        = ST_HEAD2;
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    bit        produced;
    deframed_t res;
    deframed_t due;
    if (!rst_n) begin
      st         = ST_HEAD1;
      head_byte  = 8'h00;
      bytes_left = 64'h0;
      field_cnt  = 3'd0;
      key        = 32'h0;
      key_pos    = 2'd0;
      closed     = 1'b0;
      deframed_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        deframe_rx_byte(in_rx_byte, produced, res);
        if (produced) deframed_q.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (deframed_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected beat kind=%0d data=%02h last=%0b", $realtime,
                     out_kind, out_data_byte, out_last_of_frame);
          mismatch_count++;
        end else begin
          due = deframed_q.pop_front();
          if (out_kind != due.kind || out_data_byte != due.data ||
              out_last_of_frame != due.last) begin
            if (mismatch_count < 10)
              $display("%0t: exp kind=%0d data=%02h last=%0b, got kind=%0d data=%02h last=%0b",
                       $realtime, due.kind, due.data, due.last,
                       out_kind, out_data_byte, out_last_of_frame);
            mismatch_count++;
          end
        end
      end
    end
    deframed_outstanding = deframed_q.size();
  end

endmodule

// ----- tb/websocket_frame_deframer_unit_test.sv -----
// testbench top for the websocket frame deframer: clock, reset, stimulus and verdict
module websocket_frame_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 400;   // cycles of receiver hold-off, far beyond fifo depth
  localparam int HOLD_AT_BEAT  = 300;   // input beat count that starts the hold-off
  localparam int QUIET_AT_BEAT = 1400;  // from here on neither side idles
  localparam int RANDOM_BEATS  = 1560;
  localparam int DRAIN_CYCLES  = 20;

  // how a frame encodes its payload length
  typedef enum {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} len_form_t;
  // how the stream finishes; every one but the last closes the block for good
  typedef enum {END_CLOSE, END_NO_FIN, END_OPCODE_ZERO, END_UNMASKED, END_ENDLESS} ending_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_data_byte;
  logic       out_last_of_frame;

  int mismatch_count;
  int deframed_outstanding;
  int sent_beats = 0;
  int cycle_count = 0;
  bit quiet_tail = 1'b0;   // no idling on either side once set
  bit sender_calm = 1'b0;  // per-frame stretch with no input gaps

  websocket_frame_deframer_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_data_byte     (out_data_byte),
    .out_last_of_frame (out_last_of_frame)
  );

  deframe_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_kind             (out_kind),
    .out_data_byte        (out_data_byte),
    .out_last_of_frame    (out_last_of_frame),
    .mismatch_count       (mismatch_count),
    .deframed_outstanding (deframed_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost beat ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("websocket_frame_deframer_unit test failed");
      $finish;
    end
  end

  // offer one byte and hold it until the block takes it; sometimes idle first
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    if (!quiet_tail && !sender_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_beats++;
  endtask

  // valid data header: fin set, random reserved bits, nonzero opcode, never a close
  function automatic logic [7:0] random_head();
    logic [7:0] head;
    head = {1'b1, 3'($urandom), 4'($urandom_range(1, 15))};
    if (head == wsd_pkg::CLOSE_BYTE) head = 8'h89;
    return head;
  endfunction

  // header, length field in the chosen form (big-endian) and the four key bytes
  task automatic send_frame_head(input logic [7:0] head, input len_form_t form,
                                 input logic [63:0] flen, input logic [31:0] key);
    send_byte(head);
    case (form)
      LEN_SHORT: send_byte({1'b1, flen[6:0]});
      LEN_WIDE16: begin
        send_byte({1'b1, wsd_pkg::LEN_EXT16});
        send_byte(flen[15:8]);
        send_byte(flen[7:0]);
      end
      LEN_WIDE64: begin
        send_byte({1'b1, wsd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(flen[8*i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
  endtask

  // well-formed masked frame; mostly short payloads, some near and past the 7-bit limit
  task automatic send_random_frame();
    logic [63:0] flen;
    len_form_t   form;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) flen = 64'($urandom_range(0, 12));
    else if (pick < 65) flen = 64'($urandom_range(100, 125));
    else if (pick < 70) flen = 64'($urandom_range(126, 400));
    else flen = 64'($urandom_range(0, 30));
    // extended forms may carry small values too, nothing checks minimal encoding
    pick = $urandom_range(0, 9);
    if (flen > 64'd125) begin
      if (pick < 3) form = LEN_WIDE64;
      else form = LEN_WIDE16;
    end else if (pick < 6) begin
      form = LEN_SHORT;
    end else if (pick < 8) begin
      form = LEN_WIDE16;
    end else begin
      form = LEN_WIDE64;
    end
    sender_calm = ($urandom_range(0, 3) == 0);
    send_frame_head(random_head(), form, flen, $urandom);
    repeat (int'(flen)) send_byte(8'($urandom));
  endtask

  // receiver: random not-ready bursts, calm stretches, and one long hold-off
  initial begin : result_sink
    int unsigned idle_left;
    int unsigned calm_left;
    bit          long_hold_done;
    idle_left      = 0;
    calm_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (quiet_tail || !rst_n) begin
        out_ready <= 1'b1;
      end else if (sent_beats >= HOLD_AT_BEAT && !long_hold_done) begin
        // fifo fills, in_ready must drop while the sender keeps offering bytes
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_left > 0) begin
        out_ready <= 1'b0;
        idle_left--;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            // not-ready burst that starts with this cycle
            idle_left = $urandom_range(0, 8);
            out_ready <= 1'b0;
          end
          3: begin
            calm_left = $urandom_range(30, 120);
            out_ready <= 1'b1;
          end
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  opening[$];
    logic [63:0] endless_len;
    ending_t     ending;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // opening frames: empty 7-bit frame with all-zero key,
    // 16-bit length with all-ones key and extreme payload bytes,
    // 64-bit length of one with reserved bits set in the header
    opening = '{8'h81, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h8f, 8'hfe, 8'h00, 8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff,
                8'hf2, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                8'h12, 8'h34, 8'h56, 8'h78, 8'ha5};
    foreach (opening[i]) send_byte(opening[i]);

    while (sent_beats < RANDOM_BEATS) begin
      if (sent_beats >= QUIET_AT_BEAT) quiet_tail = 1'b1;
      send_random_frame();
    end
    quiet_tail  = 1'b1;
    sender_calm = 1'b0;

    // one terminal case per run, then trailing bytes that must stay silent
    // (or, for the endless frame, keep coming out as payload)
    ending = ending_t'($urandom_range(0, 4));
    case (ending)
      END_CLOSE: begin
        send_byte(wsd_pkg::CLOSE_BYTE);
        send_byte(8'($urandom));
      end
      END_NO_FIN: begin
        send_byte({1'b0, 7'($urandom)});
        send_byte(8'($urandom));
      end
      END_OPCODE_ZERO: begin
        send_byte({1'b1, 3'($urandom), 4'h0});
        send_byte(8'($urandom));
      end
      END_UNMASKED: begin
        send_byte(random_head());
        send_byte({1'b0, 7'($urandom)});
      end
      END_ENDLESS: begin
        // top length byte nonzero: the frame outlasts the run
        endless_len = {$urandom, $urandom};
        endless_len[63:56] = 8'($urandom_range(1, 255));
        send_frame_head(random_head(), LEN_WIDE64, endless_len, $urandom);
      end
    endcase
    repeat (30) send_byte(8'($urandom));
    in_valid <= 1'b0;

    // drain, then give the pipeline time to show any stray beat
    @(posedge clk);
    while (deframed_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("websocket_frame_deframer_unit test passed");
    else $display("websocket_frame_deframer_unit test failed");
    $finish;
  end

endmodule
